[src/csfr_pkg.sv]
// Shared types, constants and helpers of the chained sector file reader.
`default_nettype none

package csfr_pkg;

    // Result kinds
    localparam logic [1:0] KIND_FETCH   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Fetch sources
    localparam logic TGT_INDEX = 1'b0;
    localparam logic TGT_DATA  = 1'b1;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_ARCHIVE_ID   = 2'd0;
    localparam logic [1:0] REG_MAX_SIZE     = 2'd1;
    localparam logic [1:0] REG_SECTOR_COUNT = 2'd2;

    localparam int APB_AW = 4;

    // Storage layout
    localparam logic [9:0]  INDEX_BYTES  = 10'd6;
    localparam logic [9:0]  HEADER_BYTES = 10'd8;
    localparam logic [9:0]  PAYLOAD_MAX  = 10'd512;
    localparam logic [25:0] SEEK_LIMIT   = 26'h3C00000;

    localparam int IDX_OFF_W   = 19;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  archive_id;
        logic [23:0] max_size;
        logic [23:0] sector_count;
    } t_cfg;

    typedef struct packed {
        logic                 is_start;
        logic [15:0]          file_id;
        logic [IDX_OFF_W-1:0] index_off;
        logic [7:0]           data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        target;
        logic [25:0] offset;
        logic [9:0]  length;
        logic [7:0]  payload;
        logic        last;
    } t_result;

    // sector * 520, clamped to the seek limit
    function automatic logic [25:0] sector_offset(input logic [23:0] sector);
        logic [33:0] prod;
        prod = {1'b0, sector, 9'd0} + {7'd0, sector, 3'd0};
        if (prod > {8'd0, SEEK_LIMIT}) begin
            return SEEK_LIMIT;
        end
        return prod[25:0];
    endfunction

    // bytes still owed, capped to one sector payload
    function automatic logic [9:0] chunk_of(input logic [23:0] remain);
        if (remain > {14'd0, PAYLOAD_MAX}) begin
            return PAYLOAD_MAX;
        end
        return remain[9:0];
    endfunction

endpackage

`default_nettype wire

[src/csfr_if.sv]
// Request and result channel interfaces of the chained sector file reader.
`default_nettype none

interface csfr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] file_id;
    logic [7:0]  data_byte;

    modport source (output valid, cmd, file_id, data_byte, input ready);
    modport sink (input valid, cmd, file_id, data_byte, output ready);
endinterface

interface csfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        target;
    logic [25:0] offset;
    logic [9:0]  length;
    logic [7:0]  payload;
    logic        last;

    modport source (output valid, kind, target, offset, length, payload, last,
                    input ready);
    modport sink (input valid, kind, target, offset, length, payload, last,
                  output ready);
endinterface

`default_nettype wire

[src/csfr_regs.sv]
// APB register block: archive id, size limit and sector count.
`default_nettype none

module csfr_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [csfr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output csfr_pkg::t_cfg                    o_cfg
);
    import csfr_pkg::*;

    logic [7:0]  r_archive_id;
    logic [23:0] r_max_size;
    logic [23:0] r_sector_count;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_archive_id   <= 8'd0;
            r_max_size     <= 24'hFFFFFF;
            r_sector_count <= 24'd0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ARCHIVE_ID:   r_archive_id   <= pwdata[7:0];
                REG_MAX_SIZE:     r_max_size     <= pwdata[23:0];
                REG_SECTOR_COUNT: r_sector_count <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_ARCHIVE_ID:   prdata = {24'd0, r_archive_id};
            REG_MAX_SIZE:     prdata = {8'd0, r_max_size};
            REG_SECTOR_COUNT: prdata = {8'd0, r_sector_count};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{archive_id: r_archive_id, max_size: r_max_size,
                     sector_count: r_sector_count};

endmodule

`default_nettype wire

[src/csfr_front.sv]
// Front stage: takes requests, classifies them and computes the index offset.
`default_nettype none

module csfr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_cmd,
    input  wire logic [15:0]     i_file_id,
    input  wire logic [7:0]      i_data_byte,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output csfr_pkg::t_item      o_item
);
    import csfr_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // classify; index entry sits at file_id * 6
    always_comb begin
        n_item.is_start  = (i_cmd == CMD_START);
        n_item.file_id   = i_file_id;
        n_item.index_off = {1'b0, i_file_id, 2'b00} + {2'b00, i_file_id, 1'b0};
        n_item.data_byte = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[src/csfr_queue.sv]
// Small FIFO between the front stage and the sequencer.
`default_nettype none

module csfr_queue #(
    parameter int DEPTH = csfr_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  csfr_pkg::t_item      i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output csfr_pkg::t_item      o_item
);
    import csfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[src/csfr_back.sv]
// Sequencer: walks index entry, sector headers and payload, emits results.
`default_nettype none

module csfr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  csfr_pkg::t_cfg       i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  csfr_pkg::t_item      i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output csfr_pkg::t_result    o_res
);
    import csfr_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_INDEX   = 2'd1;
    localparam logic [1:0] PH_HEADER  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [9:0]  r_idx, n_idx;
    logic [15:0] r_wanted, n_wanted;
    logic [23:0] r_remain, n_remain;
    logic [23:0] r_sector, n_sector;
    logic [15:0] r_part, n_part;
    logic [55:0] r_hdr, n_hdr;
    logic [9:0]  r_chunk, n_chunk;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_pend_valid;
    t_result     r_pend;

    logic        out_free;
    logic        take;
    t_result     res0, res1;
    logic [1:0]  nres;
    logic [55:0] hdr_shift;
    logic [23:0] size_new, sector_new, remain_new;
    logic [15:0] hdr_file, hdr_part;
    logic [10:0] idx_inc;
    logic [9:0]  avail;

    assign out_free = !r_out_valid || i_ready;
    assign take     = i_valid && !r_pend_valid && out_free;
    assign o_ready  = take;

    assign hdr_shift  = {r_hdr[47:0], i_item.data_byte};
    assign size_new   = hdr_shift[47:24];
    assign sector_new = hdr_shift[23:0];
    assign hdr_file   = r_hdr[55:40];
    assign hdr_part   = r_hdr[39:24];
    assign idx_inc    = {1'b0, r_idx} + 11'd1;
    assign remain_new = r_remain - {14'd0, r_chunk};

    // per-item step
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_wanted = r_wanted;
        n_remain = r_remain;
        n_sector = r_sector;
        n_part   = r_part;
        n_hdr    = r_hdr;
        n_chunk  = r_chunk;
        res0     = '0;
        res1     = '0;
        nres     = 2'd0;
        avail    = '0;
        if (take) begin
            if (i_item.is_start) begin
                // new read always wins over a running one
                n_wanted    = i_item.file_id;
                n_idx       = '0;
                n_hdr       = '0;
                n_phase     = PH_INDEX;
                res0.kind   = KIND_FETCH;
                res0.target = TGT_INDEX;
                res0.offset = {{(26 - IDX_OFF_W){1'b0}}, i_item.index_off};
                res0.length = INDEX_BYTES;
                res0.last   = 1'b1;
                nres        = 2'd1;
            end else begin
                case (r_phase)
                    PH_INDEX: begin
                        n_hdr = hdr_shift;
                        n_idx = idx_inc[9:0];
                        if (r_idx == INDEX_BYTES - 10'd1) begin
                            n_sector  = sector_new;
                            n_remain  = size_new;
                            n_part    = '0;
                            nres      = 2'd1;
                            res0.last = 1'b1;
                            if (size_new > i_cfg.max_size || sector_new == 24'd0 ||
                                sector_new > i_cfg.sector_count) begin
                                n_phase   = PH_IDLE;
                                res0.kind = KIND_ERROR;
                            end else if (size_new == 24'd0) begin
                                n_phase   = PH_IDLE;
                                res0.kind = KIND_DONE;
                            end else begin
                                avail       = chunk_of(size_new);
                                n_chunk     = avail;
                                n_idx       = '0;
                                n_hdr       = '0;
                                n_phase     = PH_HEADER;
                                res0.kind   = KIND_FETCH;
                                res0.target = TGT_DATA;
                                res0.offset = sector_offset(sector_new);
                                res0.length = avail + HEADER_BYTES;
                            end
                        end
                    end
                    PH_HEADER: begin
                        n_idx = idx_inc[9:0];
                        if (r_idx < HEADER_BYTES - 10'd1) begin
                            n_hdr = hdr_shift;
                        end else if (hdr_file != r_wanted || hdr_part != r_part ||
                                     i_item.data_byte != i_cfg.archive_id ||
                                     r_hdr[23:0] > i_cfg.sector_count) begin
                            n_phase   = PH_IDLE;
                            res0.kind = KIND_ERROR;
                            res0.last = 1'b1;
                            nres      = 2'd1;
                        end else begin
                            n_sector = r_hdr[23:0];
                            n_idx    = '0;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_idx        = idx_inc[9:0];
                        res0.kind    = KIND_PAYLOAD;
                        res0.payload = i_item.data_byte;
                        if (idx_inc < {1'b0, r_chunk}) begin
                            res0.last = 1'b1;
                            nres      = 2'd1;
                        end else begin
                            // sector finished: done, broken chain or next fetch
                            res0.last = 1'b0;
                            nres      = 2'd2;
                            n_remain  = remain_new;
                            n_part    = r_part + 16'd1;
                            res1.last = 1'b1;
                            if (remain_new == 24'd0) begin
                                n_phase   = PH_IDLE;
                                res1.kind = KIND_DONE;
                            end else if (r_sector == 24'd0) begin
                                n_phase   = PH_IDLE;
                                res1.kind = KIND_ERROR;
                            end else begin
                                avail       = chunk_of(remain_new);
                                n_chunk     = avail;
                                n_idx       = '0;
                                n_hdr       = '0;
                                n_phase     = PH_HEADER;
                                res1.kind   = KIND_FETCH;
                                res1.target = TGT_DATA;
                                res1.offset = sector_offset(r_sector);
                                res1.length = avail + HEADER_BYTES;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (take && nres != 2'd0) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (nres == 2'd2);
            end else if (r_pend_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath state and result registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wanted <= n_wanted;
        r_remain <= n_remain;
        r_sector <= n_sector;
        r_part   <= n_part;
        r_hdr    <= n_hdr;
        r_chunk  <= n_chunk;
        if (take && nres != 2'd0) begin
            r_out  <= res0;
            r_pend <= res1;
        end else if (r_pend_valid && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

[src/chained_sector_file_reader.sv]
// Chained sector file reader: reads a file through an index entry and a
// chain of 520-byte sectors, turning fetched bytes into requests and payload.
// Channels: i_req carries start requests (cmd 0, file_id) and fetched bytes
// (cmd 1, data_byte); o_rsp carries fetch requests, payload bytes, done and
// error results; the APB port sets archive id, size limit and sector count.
// A request accepted on i_req passes the front register, the queue and the
// result register before its first result shows on o_rsp. Throughput: one
// request per cycle while o_rsp is ready; a byte that ends a sector gives two
// results and holds the sequencer until the second is in its output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the queue; the registers go back to archive 0, size limit 0xFFFFFF and
// sector count 0.
// When the receiver stalls, the result register and the spare result hold,
// the 4-deep queue and the front register fill, and then i_req.ready drops.
// The user must write configuration only while no read is in flight; the block itself does not enforce this.
`default_nettype none

module chained_sector_file_reader #(
    parameter int QUEUE_DEPTH = csfr_pkg::QUEUE_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    csfr_in_if.sink                           i_req,
    csfr_out_if.source                        o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [csfr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import csfr_pkg::*;

    t_cfg    cfg;
    logic    front_valid, front_ready;
    t_item   front_item;
    logic    q_valid, q_ready;
    t_item   q_item;
    t_result res;

    csfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_cmd       (i_req.cmd),
        .i_file_id   (i_req.file_id),
        .i_data_byte (i_req.data_byte),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_item      (front_item)
    );

    csfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    csfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_res   (res)
    );

    assign o_rsp.kind    = res.kind;
    assign o_rsp.target  = res.target;
    assign o_rsp.offset  = res.offset;
    assign o_rsp.length  = res.length;
    assign o_rsp.payload = res.payload;
    assign o_rsp.last    = res.last;

endmodule

`default_nettype wire
